// ===== design/hsns_pkg.sv =====
`timescale 1ns / 1ps

package hsns_pkg;

    // action codes of an input beat
    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_PROBE  = 3'd1;
    localparam logic [2:0] ACT_OK     = 3'd2;
    localparam logic [2:0] ACT_FAIL   = 3'd3;
    localparam logic [2:0] ACT_SELECT = 3'd4;

    // widths that cover the largest table (64 entries)
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int SCORE_W = 22;

    localparam logic [19:0] LAT_MAX = 20'hFFFFF;
    localparam logic [SCORE_W-1:0] FAIL_PENALTY = 22'd1600;
    localparam logic [SCORE_W-1:0] PEER_BONUS = 22'd160;
    localparam logic [SCORE_W-1:0] BONUS_OFFSET = 22'd800;
    localparam logic [9:0] PEER_CAP = 10'd5;
    localparam logic [7:0] FAIL_MAX = 8'd255;
    localparam logic [7:0] MAX_FAIL_RESET = 8'd3;
    // ceil(2^27 / 10) == ceil(2^26 / 5)
    localparam logic [23:0] RECIP = 24'd13421773;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] node_key;
        logic [3:0]  node_slot;
        logic        reachable;
        logic [9:0]  peers_seen;
        logic [15:0] rtt_ms;
    } in_t;

    typedef struct packed {
        logic [3:0] current_slot;
        logic       has_current;
        logic       node_changed;
        logic       none_available;
        logic       probe_good;
        logic       duplicate;
        logic       entry_dropped;
        logic [4:0] good_count;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [47:0] tag;
        logic        up;
        logic [19:0] lat;
        logic [7:0]  fail;
        logic [9:0]  peers;
    } entry_t;

    // entry rewrite from the sequencer
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             up;
        logic [19:0]      lat;
        logic [7:0]       fail;
        logic [9:0]       peers;
    } wr_t;

    // scan record handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               found;
        logic [IDX_W-1:0]   best;
        logic [SCORE_W-1:0] score;
        logic               dup;
        logic [CNT_W-1:0]   cnt;
        logic               last_good;
    } sweep_t;

endpackage

// ===== design/hsns_cell.sv =====
`timescale 1ns / 1ps

module hsns_cell import hsns_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  entry_t      prev_entry,
    output entry_t      entry,
    input  logic        shift,
    input  logic [47:0] key,
    input  wr_t         wr,
    input  logic [7:0]  max_failures,
    input  sweep_t      sw_in,
    output sweep_t      sw_out
);

    entry_t ent_reg, ent_next;
    sweep_t sw_reg, sw_next;
    logic good;
    logic [2:0] peer_cnt;
    logic [SCORE_W-1:0] score;

    // entry update: shift from neighbor or rewrite
    always_comb begin
        ent_next = ent_reg;
        if (shift) begin
            if (IDX == 0) begin
                ent_next.valid = 1'b1;
                ent_next.tag   = key;
                ent_next.up    = 1'b0;
                ent_next.lat   = '0;
                ent_next.fail  = '0;
                ent_next.peers = '0;
            end else begin
                ent_next = prev_entry;
            end
        end else if (wr.en && wr.idx == IDX_W'(IDX)) begin
            ent_next.up    = wr.up;
            ent_next.lat   = wr.lat;
            ent_next.fail  = wr.fail;
            ent_next.peers = wr.peers;
        end
    end

    always_ff @(posedge aclk) begin
        // key holds no reset, gated by valid
        ent_reg.tag <= ent_next.tag;
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
            ent_reg.up    <= 1'b0;
            ent_reg.lat   <= '0;
            ent_reg.fail  <= '0;
            ent_reg.peers <= '0;
        end else begin
            ent_reg.valid <= ent_next.valid;
            ent_reg.up    <= ent_next.up;
            ent_reg.lat   <= ent_next.lat;
            ent_reg.fail  <= ent_next.fail;
            ent_reg.peers <= ent_next.peers;
        end
    end

    assign entry = ent_reg;

    // score and health of this entry
    always_comb begin
        good = ent_reg.valid && ent_reg.up && ent_reg.peers >= 10'd2 &&
               ent_reg.fail < max_failures;
        peer_cnt = (ent_reg.peers < PEER_CAP) ? ent_reg.peers[2:0] : PEER_CAP[2:0];
        score = SCORE_W'(ent_reg.lat) + SCORE_W'(ent_reg.fail) * FAIL_PENALTY +
                BONUS_OFFSET - SCORE_W'(peer_cnt) * PEER_BONUS;
    end

    // fold this entry into the passing scan record
    always_comb begin
        sw_next = sw_in;
        if (sw_in.active) begin
            if (ent_reg.valid && ent_reg.up && (!sw_in.found || score < sw_in.score)) begin
                sw_next.found = 1'b1;
                sw_next.best  = IDX_W'(IDX);
                sw_next.score = score;
            end
            sw_next.dup       = sw_in.dup || (ent_reg.valid && ent_reg.tag == key);
            sw_next.cnt       = sw_in.cnt + CNT_W'(good);
            sw_next.last_good = good;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= '0;
        end else begin
            sw_reg <= sw_next;
        end
    end

    assign sw_out = sw_reg;

endmodule

// ===== design/health_scored_node_selector_unit.sv =====
`timescale 1ns / 1ps

// channel   | ports                      | payload
// event in  | s_valid s_ready s_data     | in_t: action, key, slot, probe fields
// result    | m_valid m_ready m_data     | out_t: current node and status flags
// config    | cfg_valid cfg_ready cfg_data | max_failures, 8 bits
//
// one event at a time: add and select run the scan alone; probe, success and
// failure run the three-step latency smoothing multiply first; the scan record
// walks the cell row one cell per cycle.
// the next event can be taken in the cycle after the result beat is loaded.
// reset (aresetn low, synchronous) empties the table and clears the current node.
// a finished result waits in the output register; the next event is taken meanwhile,
// and its own result holds until the waiting beat leaves.
module health_scored_node_selector_unit import hsns_pkg::*; #(
    parameter int NODES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int SW = (NODES > 1) ? $clog2(NODES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_WRITE, ST_LAUNCH, ST_WAIT, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg;
    in_t req_reg;
    entry_t old_reg;
    logic tgt_ok_reg;
    logic [SW-1:0] tgt_idx_reg;
    logic [23:0] num_reg;
    logic [47:0] prod_reg;
    logic [SW-1:0] chosen_slot_reg;
    logic chosen_valid_reg;
    logic [7:0] maxf_reg;
    sweep_t sres_reg;
    out_t res_reg;
    logic m_valid_reg;
    out_t m_data_reg;

    entry_t ents [NODES];
    sweep_t sws [NODES];
    entry_t prev0;
    sweep_t launch;
    wr_t wr;
    logic shift;

    logic [SW-1:0] rd_idx;
    logic rd_ok;
    entry_t rd_ent;
    logic [19:0] fresh;
    logic [20:0] quo;
    logic [19:0] smoothed;
    logic [7:0] fail_inc;
    logic add_go;
    logic [CNT_W-1:0] cnt_fin;
    out_t res_next;
    logic [SW-1:0] chosen_slot_next;
    logic chosen_valid_next;

    assign prev0 = '0;

    // row of entry cells
    for (genvar i = 0; i < NODES; i++) begin : g_cell
        if (i == 0) begin : g_head
            hsns_cell #(.IDX(i)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .prev_entry(prev0), .entry(ents[i]),
                .shift(shift), .key(req_reg.node_key), .wr(wr),
                .max_failures(maxf_reg), .sw_in(launch), .sw_out(sws[i])
            );
        end else begin : g_body
            hsns_cell #(.IDX(i)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .prev_entry(ents[i-1]), .entry(ents[i]),
                .shift(shift), .key(req_reg.node_key), .wr(wr),
                .max_failures(maxf_reg), .sw_in(sws[i-1]), .sw_out(sws[i])
            );
        end
    end

    // target entry read for probe, success and failure
    always_comb begin
        fresh = {req_reg.rtt_ms, 4'b0000};
        if (req_reg.action == ACT_PROBE) begin
            rd_idx = SW'(req_reg.node_slot);
            rd_ent = ents[rd_idx];
            rd_ok  = (32'(req_reg.node_slot) < NODES) && rd_ent.valid;
        end else begin
            rd_idx = chosen_slot_reg;
            rd_ent = ents[rd_idx];
            rd_ok  = chosen_valid_reg && rd_ent.valid;
        end
    end

    // smoothed latency and failure count
    always_comb begin
        quo = (req_reg.action == ACT_PROBE) ? 21'(prod_reg >> 27) : 21'(prod_reg >> 26);
        if (old_reg.lat == '0) begin
            smoothed = fresh;
        end else if (quo > 21'(LAT_MAX)) begin
            smoothed = LAT_MAX;
        end else begin
            smoothed = quo[19:0];
        end
        fail_inc = (old_reg.fail == FAIL_MAX) ? FAIL_MAX : old_reg.fail + 8'd1;
    end

    // rewrite of the target entry
    always_comb begin
        wr = '0;
        wr.idx   = IDX_W'(tgt_idx_reg);
        wr.up    = old_reg.up;
        wr.lat   = old_reg.lat;
        wr.fail  = old_reg.fail;
        wr.peers = old_reg.peers;
        if (state_reg == ST_WRITE) begin
            wr.en = tgt_ok_reg;
            case (req_reg.action)
                ACT_PROBE: begin
                    wr.peers = req_reg.peers_seen;
                    if (req_reg.reachable) begin
                        wr.up   = 1'b1;
                        wr.fail = '0;
                        wr.lat  = smoothed;
                    end else begin
                        wr.up   = 1'b0;
                        wr.fail = fail_inc;
                    end
                end
                ACT_OK: begin
                    wr.up   = 1'b1;
                    wr.fail = '0;
                    wr.lat  = smoothed;
                end
                ACT_FAIL: begin
                    wr.fail = fail_inc;
                    if (fail_inc >= maxf_reg) begin
                        wr.up = 1'b0;
                    end
                end
                default: begin
                    wr.en = 1'b0;
                end
            endcase
        end
    end

    // scan start and add shift
    always_comb begin
        launch = '0;
        launch.active = (state_reg == ST_LAUNCH);
        add_go = (req_reg.action == ACT_ADD) && !sres_reg.dup;
        shift = (state_reg == ST_FIN) && add_go;
        cnt_fin = add_go ? sres_reg.cnt - CNT_W'(sres_reg.last_good) : sres_reg.cnt;
    end

    // result and current node after the scan
    always_comb begin
        res_next          = '0;
        chosen_slot_next  = chosen_slot_reg;
        chosen_valid_next = chosen_valid_reg;
        case (req_reg.action)
            ACT_ADD: begin
                res_next.duplicate = sres_reg.dup;
                if (add_go) begin
                    res_next.entry_dropped = ents[NODES-1].valid;
                    if (chosen_valid_reg) begin
                        if (32'(chosen_slot_reg) + 1 >= NODES) begin
                            chosen_valid_next = 1'b0;
                        end else begin
                            chosen_slot_next = chosen_slot_reg + 1'b1;
                        end
                    end
                end
            end
            ACT_PROBE: begin
                res_next.probe_good = tgt_ok_reg && req_reg.reachable &&
                                      req_reg.peers_seen >= 10'd2;
            end
            ACT_SELECT: begin
                if (!sres_reg.found) begin
                    res_next.none_available = 1'b1;
                end else if (!chosen_valid_reg ||
                             IDX_W'(chosen_slot_reg) != sres_reg.best) begin
                    chosen_slot_next      = SW'(sres_reg.best);
                    chosen_valid_next     = 1'b1;
                    res_next.node_changed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res_next.current_slot = chosen_valid_next ? 4'(chosen_slot_next) : 4'd0;
        res_next.has_current  = chosen_valid_next;
        res_next.good_count   = (cnt_fin > CNT_W'(31)) ? 5'd31 : 5'(cnt_fin);
    end

    // sequencer and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            chosen_slot_reg  <= '0;
            chosen_valid_reg <= 1'b0;
            maxf_reg         <= MAX_FAIL_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                maxf_reg <= cfg_data;
            end
            // output beat load and release
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_data_reg  <= res_reg;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg <= s_data;
                        if (s_data.action == ACT_PROBE || s_data.action == ACT_OK ||
                            s_data.action == ACT_FAIL) begin
                            state_reg <= ST_READ;
                        end else begin
                            state_reg <= ST_LAUNCH;
                        end
                    end
                end
                ST_READ: begin
                    tgt_idx_reg <= rd_idx;
                    tgt_ok_reg  <= rd_ok;
                    old_reg     <= rd_ent;
                    if (req_reg.action == ACT_PROBE) begin
                        num_reg <= 24'(rd_ent.lat) * 24'd7 + 24'(fresh) * 24'd3 + 24'd5;
                    end else begin
                        num_reg <= 24'(rd_ent.lat) * 24'd4 + 24'(fresh) + 24'd2;
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= 48'(num_reg) * 48'(RECIP);
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    state_reg <= ST_LAUNCH;
                end
                ST_LAUNCH: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (sws[NODES-1].active) begin
                        sres_reg  <= sws[NODES-1];
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    res_reg          <= res_next;
                    chosen_slot_reg  <= chosen_slot_next;
                    chosen_valid_reg <= chosen_valid_next;
                    state_reg        <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // current node always points inside the table
    a_chosen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        chosen_valid_reg |-> (32'(chosen_slot_reg) < NODES))
        else $error("current slot beyond table");

    // scan record leaves the row only while waited for
    a_sweep_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sws[NODES-1].active |-> state_reg == ST_WAIT)
        else $error("stray scan record");

    // changed node implies a current node
    a_changed_current: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.node_changed |-> m_data.has_current)
        else $error("node changed without current node");

    // duplicate add never drops an entry
    a_dup_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.duplicate |-> !m_data.entry_dropped)
        else $error("duplicate add dropped an entry");

    // shift only happens once per add
    a_shift_once: assert property (@(posedge aclk) disable iff (!aresetn)
        shift |=> !shift)
        else $error("table shifted twice");

endmodule
